/* rtl/arx_pkg.sv */
// Package for the ARX plant step: sizes, register indexes and sequencer states.
`timescale 1ns / 1ps

package arx_pkg;

  localparam int A_TAPS    = 3;
  localparam int B_TAPS    = 3;
  localparam int MAX_DELAY = 15;
  localparam int IN_LEN    = B_TAPS + MAX_DELAY;
  localparam int REG_TAPS  = 3;   // taps that have a coefficient register

  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 32;
  localparam int DELAY_W   = 4;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_SH   = 24;  // Q16.16 * Q8.24 -> Q.40, back to Q.16
  localparam int ACC_W     = 68;

  localparam int NUM_STEPS = A_TAPS + B_TAPS;
  localparam int STEP_W    = $clog2(NUM_STEPS + 1);
  localparam int IN_IDX_W  = $clog2(IN_LEN);
  localparam int OUT_IDX_W = (A_TAPS > 1) ? $clog2(A_TAPS) : 1;
  localparam int SUM_IDX_W = IN_IDX_W + 1;
  localparam int RTAP_W    = $clog2(REG_TAPS);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_A1    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_A2    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_A3    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_B1    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_B2    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_B3    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY = 3'd6;

  localparam logic [DELAY_W-1:0] DELAY_RST = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } arx_state_t;

endpackage

/* rtl/arx_model_step.sv */
// ARX plant with transport delay: one shared multiply-accumulate under a small sequencer.
`timescale 1ns / 1ps

//  channel  dir  beat fields (low bits first)
//  in_      in   tdata: control_sample[31:0], disturbance[63:32]
//  out_     out  tdata: plant_output[31:0]
//  cfg_     in   cfg_addr 0..6 = a1,a2,a3,b1,b2,b3,transport_delay; cfg_wdata
//
//  Each beat runs in order: accept, 6 multiplies through the one 32x32 multiplier
//  (3 input taps, 3 feedback taps), one drain add, then the round/saturate step.
//  The single multiplier and its accumulator force this serial order.
//  in_tready is high only while the sequencer is idle.
//  A result waits in the output register; the round cycle stalls while it is unread.
//  rst_n (synchronous) clears both history lines, coefficients and delay (delay = 1).

module arx_model_step
  import arx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // control_sample[31:0], disturbance[63:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // plant_output[31:0]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  arx_state_t state_r, state_nxt;

  logic signed [COEF_W-1:0]   coef_a_r [REG_TAPS];
  logic signed [COEF_W-1:0]   coef_b_r [REG_TAPS];
  logic [DELAY_W-1:0]         delay_r;
  logic signed [SAMPLE_W-1:0] in_hist_r  [IN_LEN];
  logic signed [SAMPLE_W-1:0] out_hist_r [A_TAPS];

  logic [STEP_W-1:0]          step_r, step_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r, prod_neg_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_tvalid_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;

  logic                       in_acc, load_out, mac_en;
  logic                       is_fb;
  logic [STEP_W-1:0]          tap;
  logic [SUM_IDX_W-1:0]       in_idx;
  logic signed [COEF_W-1:0]   op_coef;
  logic signed [SAMPLE_W-1:0] op_samp;
  logic signed [ACC_W-1:0]    prod_ext;
  logic [ACC_W-FRAC_SH-1:0]   q;
  logic [ACC_W-1:FRAC_SH+SAMPLE_W-1] q_top;
  logic [SAMPLE_W-1:0]        y;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign load_out   = (state_r == ST_FINISH) && (!out_tvalid_r || out_tready);
  assign mac_en     = (state_r == ST_MAC);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_STEPS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_TAPS; i++) begin
        coef_a_r[i] <= '0;
        coef_b_r[i] <= '0;
      end
      delay_r <= DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_A1:    coef_a_r[0] <= cfg_wdata;
        CFG_A2:    coef_a_r[1] <= cfg_wdata;
        CFG_A3:    coef_a_r[2] <= cfg_wdata;
        CFG_B1:    coef_b_r[0] <= cfg_wdata;
        CFG_B2:    coef_b_r[1] <= cfg_wdata;
        CFG_B3:    coef_b_r[2] <= cfg_wdata;
        CFG_DELAY: delay_r     <= cfg_wdata[DELAY_W-1:0];
        default:   ;
      endcase
    end
  end

  // history lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IN_LEN; i++) in_hist_r[i] <= '0;
      for (int i = 0; i < A_TAPS; i++) out_hist_r[i] <= '0;
    end else begin
      if (in_acc) begin
        in_hist_r[0] <= in_tdata[SAMPLE_W-1:0];
        for (int i = 1; i < IN_LEN; i++) in_hist_r[i] <= in_hist_r[i-1];
      end
      if (load_out) begin
        out_hist_r[0] <= y;
        for (int i = 1; i < A_TAPS; i++) out_hist_r[i] <= out_hist_r[i-1];
      end
    end
  end

  // operand select: input taps first, then feedback taps
  always_comb begin
    is_fb   = (step_r >= STEP_W'(B_TAPS));
    tap     = is_fb ? (step_r - STEP_W'(B_TAPS)) : step_r;
    in_idx  = SUM_IDX_W'(tap) + SUM_IDX_W'(delay_r);
    op_coef = '0;
    op_samp = '0;
    if (is_fb) begin
      if (tap < STEP_W'(REG_TAPS)) op_coef = coef_a_r[tap[RTAP_W-1:0]];
      if (tap < STEP_W'(A_TAPS)) op_samp = out_hist_r[tap[OUT_IDX_W-1:0]];
    end else begin
      if (tap < STEP_W'(REG_TAPS)) op_coef = coef_b_r[tap[RTAP_W-1:0]];
      // taps reaching past the line contribute zero
      if (in_idx < SUM_IDX_W'(IN_LEN)) op_samp = in_hist_r[in_idx[IN_IDX_W-1:0]];
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  // multiply into a register, then accumulate the registered product in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mac_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_en) begin
      prod_r     <= op_coef * op_samp;
      prod_neg_r <= is_fb;
    end
    if (in_acc) begin
      // z aligned to Q.40 plus the half-LSB rounding bias
      acc_r <= {{(ACC_W-FRAC_SH-SAMPLE_W){in_tdata[63]}}, in_tdata[63:32],
                1'b1, {(FRAC_SH-1){1'b0}}};
    end else if (prod_vld_r) begin
      acc_r <= prod_neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  // floor shift, then saturate to 32 bits
  always_comb begin
    q     = acc_r[ACC_W-1:FRAC_SH];
    q_top = acc_r[ACC_W-1:FRAC_SH+SAMPLE_W-1];
    if ((&q_top) || !(|q_top)) y = q[SAMPLE_W-1:0];
    else if (q[ACC_W-FRAC_SH-1])  y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else                          y = {1'b0, {(SAMPLE_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_tdata_r <= y;
  end

  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_MAC && step_r == '0)
    else $error("accepted beat did not start the MAC sequence");

  a_prod_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    prod_vld_r |-> state_r == ST_MAC || state_r == ST_DRAIN)
    else $error("product pending outside the MAC window");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared without a finish cycle");

  a_history_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_hist_r[0] == out_tdata && out_tvalid)
    else $error("feedback history and delivered result differ");

endmodule

/* verif/arx_model_step_tb.sv */
// Testbench for arx_model_step: directed and random sample streams checked against a plant predictor.
`timescale 1ns / 1ps

module arx_model_step_tb;
  import arx_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 168;
  localparam int MAX_REPORTS = 20;
  localparam int DRAIN_WAIT  = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_NONE = 3'd7;  // no register behind this index

  localparam logic [31:0] S_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN   = 32'h8000_0000;
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [31:0] NEG_ONE = 32'hff00_0000;
  localparam logic [31:0] HALF_Q24 = 32'h0080_0000;

  localparam logic signed [127:0] Y_HI = 128'sd2147483647;
  localparam logic signed [127:0] Y_LO = -128'sd2147483648;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;   // control_sample[31:0], disturbance[63:32]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;       // plant_output[31:0]
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the plant
  logic signed [31:0] coef_a [REG_TAPS] = '{default: '0};
  logic signed [31:0] coef_b [REG_TAPS] = '{default: '0};
  logic [DELAY_W-1:0] delay_q = DELAY_RST;
  logic signed [31:0] u_line [IN_LEN] = '{default: '0};
  logic signed [31:0] y_line [A_TAPS] = '{default: '0};

  logic [31:0] expected_y [$];
  logic [31:0] want_y;
  int          mismatches = 0;
  int          cycles = 0;
  bit          steady = 1'b0;

  arx_model_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_y.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: extra beat, expected none, actual plant_output=%h", $time, out_tdata);
      end else begin
        want_y = expected_y.pop_front();
        if (out_tdata !== want_y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: plant_output expected %h actual %h", $time, want_y, out_tdata);
        end
      end
    end
  end

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_A1:    coef_a[0] = data;
      CFG_A2:    coef_a[1] = data;
      CFG_A3:    coef_a[2] = data;
      CFG_B1:    coef_b[0] = data;
      CFG_B2:    coef_b[1] = data;
      CFG_B3:    coef_b[2] = data;
      CFG_DELAY: delay_q = data[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  // One plant step: shift u in, exact sum in Q.40, round half up, saturate, shift y in.
  function automatic logic [31:0] plant_step(input logic signed [31:0] u,
                                             input logic signed [31:0] z);
    logic signed [127:0] acc;
    logic signed [127:0] q;
    logic signed [31:0]  y;
    int                  idx;
    acc = '0;
    for (int j = IN_LEN - 1; j > 0; j--) u_line[j] = u_line[j - 1];
    u_line[0] = u;
    for (int j = 0; j < B_TAPS; j++) begin
      idx = j + delay_q;
      if (j < REG_TAPS && idx < IN_LEN) acc = acc + coef_b[j] * u_line[idx];
    end
    for (int j = 0; j < A_TAPS; j++) begin
      if (j < REG_TAPS) acc = acc - coef_a[j] * y_line[j];
    end
    acc = acc + (z <<< FRAC_SH);
    acc = acc + (128'sd1 <<< (FRAC_SH - 1));
    q = acc >>> FRAC_SH;
    if (q > Y_HI) y = S_MAX;
    else if (q < Y_LO) y = S_MIN;
    else y = q[31:0];
    for (int j = A_TAPS - 1; j > 0; j--) y_line[j] = y_line[j - 1];
    y_line[0] = y;
    return y;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;  // about +-16.0
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input bit full, input int unsigned span);
    if (full || $urandom_range(15) == 0) return $urandom;
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(input logic [31:0] a1, a2, a3, b1, b2, b3, dly);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_A3, a3);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_B3, b3);
    write_reg(CFG_DELAY, dly);
  endtask

  // valid is left high after the beat; the next call may lower it for a random gap, drain_results lowers it
  task automatic send_sample(input logic [31:0] u, input logic [31:0] z);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 11) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, u};
    do @(posedge clk); while (!in_tready);
    expected_y.insert(expected_y.size(), plant_step(u, z));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_y.size() != 0) @(posedge clk);
  endtask

  // all coefficients zero after reset: y follows z
  task automatic test_reset_state();
    send_sample(S_MAX, 32'h0000_0000);
    send_sample(S_MIN, S_MAX);
    send_sample(32'h0000_0000, S_MIN);
    drain_results();
  endtask

  // b1 = 1.0, no delay (upper bits of the delay write must be dropped)
  task automatic test_unity_gain();
    load_regs('0, '0, '0, ONE_Q24, '0, '0, 32'hffff_fff0);
    send_sample(32'h0001_0000, 32'h0002_0000);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MIN, S_MAX);
    drain_results();
  endtask

  // b1 = 0.5: odd LSB inputs land on the half point
  task automatic test_rounding();
    load_regs('0, '0, '0, HALF_Q24, '0, '0, 32'h0);
    send_sample(32'h0000_0001, '0);
    send_sample(32'hffff_ffff, '0);
    send_sample(32'h0000_0003, '0);
    send_sample(32'hffff_fffd, '0);
    drain_results();
  endtask

  // a = -1.0 on all taps: y accumulates until it saturates
  task automatic test_feedback();
    load_regs(NEG_ONE, NEG_ONE, NEG_ONE, ONE_Q24, '0, '0, 32'h0);
    repeat (4) send_sample(32'h7fff_0000, 32'h0001_0000);
    drain_results();
  endtask

  // full-scale coefficients at the longest delay; the unmapped index must not disturb them
  task automatic test_extreme_coefs();
    load_regs(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 32'h0000_000f);
    write_reg(CFG_NONE, $urandom);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    drain_results();
    load_regs(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 32'h0000_000f);
    send_sample(S_MAX, '0);
    send_sample(S_MIN, '0);
    drain_results();
  endtask

  task automatic test_random_phases();
    bit full;
    for (int p = 0; p < RAND_PHASES; p++) begin
      steady = (p == 3);
      full   = (p == 1) || ($urandom_range(3) == 0);
      if (p == 0) begin
        load_regs(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 32'h0);
      end else begin
        // small feedback keeps the plant stable so y mostly stays off the rails
        load_regs(rand_coef(full, 32'h0040_0000), rand_coef(full, 32'h0040_0000),
                  rand_coef(full, 32'h0040_0000), rand_coef(full, 32'h0100_0000),
                  rand_coef(full, 32'h0100_0000), rand_coef(full, 32'h0100_0000),
                  ($urandom & 32'hffff_fff0) | ((p == 1) ? 32'hf : $urandom_range(15)));
      end
      write_reg(CFG_NONE, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(rand_sample(), rand_sample());
      drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_unity_gain();
    test_rounding();
    test_feedback();
    test_extreme_coefs();
    test_random_phases();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_y.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/arx_pkg.sv
rtl/arx_model_step.sv
verif/arx_model_step_tb.sv
